FILE: hdl/kvl_pkg.sv
// package for the keyframe vec3 lerp sampler
// holds item, key and configuration types, register indexes and helpers
// no dependencies
package kvl_pkg;

    localparam int TIME_SHIFT = 10;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int DEN_W      = 16 + TIME_SHIFT;
    localparam int REM_W      = DEN_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_BASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BASE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_BASE    = 3'd6;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic [8:0]         key_count;
        logic signed [31:0] x_scale;
        logic signed [31:0] x_base;
        logic signed [31:0] y_scale;
        logic signed [31:0] y_base;
        logic signed [31:0] z_scale;
        logic signed [31:0] z_base;
    } t_cfg;

    typedef struct packed {
        logic               is_sample;
        logic [7:0]         key_index;
        logic [15:0]        key_time;
        logic signed [15:0] key_x;
        logic signed [15:0] key_y;
        logic signed [15:0] key_z;
        logic signed [31:0] sample_time;
    } t_item;

    typedef struct packed {
        logic [15:0]        time_c;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_key;

    // saturate a 49-bit signed sum to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [48:0] hi;
        logic signed [48:0] lo;
        hi = 49'sd2147483647;
        lo = -49'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

FILE: hdl/kvl_if.sv
// valid/ready channel interfaces for the sampler
// request channel and result channel; no dependencies
interface kvl_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [7:0]         key_index;
    logic [15:0]        key_time;
    logic signed [15:0] key_x;
    logic signed [15:0] key_y;
    logic signed [15:0] key_z;
    logic signed [31:0] sample_time;

    modport source (output valid, req_type, key_index, key_time, key_x, key_y, key_z,
                    sample_time, input ready);
    modport sink (input valid, req_type, key_index, key_time, key_x, key_y, key_z,
                  sample_time, output ready);
endinterface

interface kvl_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

FILE: hdl/kvl_front.sv
// front end: accepts request transactions, classifies them, queues two deep
// depends on kvl_pkg
module kvl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [7:0]         i_key_index,
    input  logic [15:0]        i_key_time,
    input  logic signed [15:0] i_key_x,
    input  logic signed [15:0] i_key_y,
    input  logic signed [15:0] i_key_z,
    input  logic signed [31:0] i_sample_time,
    output logic               o_q_valid,
    output kvl_pkg::t_item     o_q_item,
    input  logic               i_q_pop
);
    kvl_pkg::t_item r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;
    kvl_pkg::t_item n_item;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_slot[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_item.is_sample   = (i_req_type == kvl_pkg::REQ_SAMPLE);
        n_item.key_index   = i_key_index;
        n_item.key_time    = i_key_time;
        n_item.key_x       = i_key_x;
        n_item.key_y       = i_key_y;
        n_item.key_z       = i_key_z;
        n_item.sample_time = i_sample_time;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: hdl/kvl_back.sv
// back end: key table, binary search, fraction divider, dequantize and lerp
// depends on kvl_pkg
module kvl_back #(
    parameter int MAX_KEYS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kvl_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  kvl_pkg::t_item     i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_z
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int HW = AW + 2;
    localparam logic signed [HW-1:0] ONE = HW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_LAST, S_LASTCHK, S_SRCH, S_SCHK, S_RD0, S_RD1,
        S_DIV, S_MUL0, S_ADD0, S_MUL1, S_ADD1, S_LMUL, S_LADD
    } t_state;

    t_state                        r_state;
    kvl_pkg::t_key                 r_mem [MAX_KEYS];
    kvl_pkg::t_key                 r_rdata;
    logic [AW-1:0]                 n_rd_addr;
    logic signed [31:0]            r_t;
    logic signed [HW-1:0]          r_n;
    logic signed [HW-1:0]          r_low;
    logic signed [HW-1:0]          r_high;
    logic                          r_single;
    kvl_pkg::t_key                 r_k0;
    kvl_pkg::t_key                 r_k1;
    logic [15:0]                   r_f;
    logic [kvl_pkg::REM_W-1:0]     r_rem;
    logic [kvl_pkg::DEN_W-1:0]     r_den;
    logic [3:0]                    r_cnt;
    logic signed [47:0]            r_p [3];
    logic signed [49:0]            r_p2 [3];
    logic signed [31:0]            r_v0 [3];
    logic signed [31:0]            r_v1 [3];

    logic signed [HW-1:0]          mid;
    logic signed [HW-1:0]          idx1;
    logic signed [33:0]            t_ext;
    logic signed [33:0]            kt_fine;
    logic signed [33:0]            t0_fine;
    logic signed [33:0]            t1_fine;
    logic signed [33:0]            num;
    logic signed [33:0]            den;
    logic [kvl_pkg::REM_W-1:0]     rem_sh;
    logic signed [15:0]            q0 [3];
    logic signed [15:0]            q1 [3];
    logic signed [31:0]            scl [3];
    logic signed [31:0]            bas [3];
    int unsigned                   kc;
    int unsigned                   n_clamp;
    logic                          out_free;

    always_comb begin
        mid     = (r_low + r_high) >>> 1;
        idx1    = (r_high + ONE > r_n - ONE) ? r_n - ONE : r_high + ONE;
        t_ext   = 34'(r_t);
        kt_fine = $signed({8'd0, r_rdata.time_c, 10'd0});
        t0_fine = $signed({8'd0, r_k0.time_c, 10'd0});
        t1_fine = $signed({8'd0, r_rdata.time_c, 10'd0});
        num     = t_ext - t0_fine;
        den     = t1_fine - t0_fine;
        rem_sh  = {r_rem[kvl_pkg::REM_W-2:0], 1'b0};
        q0[0] = r_k0.x; q0[1] = r_k0.y; q0[2] = r_k0.z;
        q1[0] = r_k1.x; q1[1] = r_k1.y; q1[2] = r_k1.z;
        scl[0] = i_cfg.x_scale; scl[1] = i_cfg.y_scale; scl[2] = i_cfg.z_scale;
        bas[0] = i_cfg.x_base;  bas[1] = i_cfg.y_base;  bas[2] = i_cfg.z_base;
        kc      = 32'(i_cfg.key_count);
        n_clamp = (kc == 0) ? 1 : ((kc > MAX_KEYS) ? MAX_KEYS : kc);
        out_free = !o_valid || i_ready;
        o_q_pop  = (r_state == S_IDLE) && i_q_valid;
        case (r_state)
            S_LAST:  n_rd_addr = AW'(n_clamp - 1);
            S_SRCH: begin
                if (r_low <= r_high) n_rd_addr = mid[AW-1:0];
                else if (r_high < 0) n_rd_addr = '0;
                else                 n_rd_addr = r_high[AW-1:0];
            end
            S_RD0:   n_rd_addr = idx1[AW-1:0];
            default: n_rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[n_rd_addr];
        if (r_state == S_IDLE && i_q_valid && !i_q_item.is_sample
            && 32'(i_q_item.key_index) < MAX_KEYS) begin
            r_mem[AW'(i_q_item.key_index)] <= '{i_q_item.key_time, i_q_item.key_x,
                                                i_q_item.key_y, i_q_item.key_z};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (i_ready && !(r_state == S_LADD && out_free)) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_q_item.is_sample) begin
                        r_t     <= i_q_item.sample_time;
                        r_n     <= HW'(n_clamp);
                        r_state <= S_LAST;
                    end
                end
                S_LAST: r_state <= S_LASTCHK;
                S_LASTCHK: begin
                    if (t_ext >= kt_fine) begin
                        r_k0 <= r_rdata; r_k1 <= r_rdata; r_f <= '0;
                        r_state <= S_MUL0;
                    end else begin
                        r_low   <= '0;
                        r_high  <= r_n - ONE;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_low <= r_high) begin
                        r_state <= S_SCHK;
                    end else begin
                        r_single <= (r_high < 0);
                        r_state  <= S_RD0;
                    end
                end
                S_SCHK: begin
                    if (t_ext == kt_fine) begin
                        r_k0 <= r_rdata; r_k1 <= r_rdata; r_f <= '0;
                        r_state <= S_MUL0;
                    end else begin
                        if (t_ext > kt_fine) r_low  <= mid + ONE;
                        else                 r_high <= mid - ONE;
                        r_state <= S_SRCH;
                    end
                end
                S_RD0: begin
                    r_k0 <= r_rdata;
                    r_k1 <= r_rdata;
                    r_f  <= '0;
                    r_state <= r_single ? S_MUL0 : S_RD1;
                end
                S_RD1: begin
                    // zero or negative interval keeps the lower key
                    r_k1  <= (den <= 0) ? r_k0 : r_rdata;
                    r_den <= den[kvl_pkg::DEN_W-1:0];
                    r_rem <= kvl_pkg::REM_W'(num);
                    r_cnt <= '0;
                    if (den <= 0) begin
                        r_state <= S_MUL0;
                    end else if (num <= 0) begin
                        r_state <= S_MUL0;
                    end else if (num >= den) begin
                        r_f <= 16'hffff;
                        r_state <= S_MUL0;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem <= rem_sh - {1'b0, r_den};
                        r_f   <= {r_f[14:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_f   <= {r_f[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) r_state <= S_MUL0;
                end
                S_MUL0: begin
                    for (int i = 0; i < 3; i++) r_p[i] <= q0[i] * scl[i];
                    r_state <= S_ADD0;
                end
                S_ADD0: begin
                    for (int i = 0; i < 3; i++)
                        r_v0[i] <= kvl_pkg::sat32(49'(r_p[i]) + 49'(bas[i]));
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    for (int i = 0; i < 3; i++) r_p[i] <= q1[i] * scl[i];
                    r_state <= S_ADD1;
                end
                S_ADD1: begin
                    for (int i = 0; i < 3; i++)
                        r_v1[i] <= kvl_pkg::sat32(49'(r_p[i]) + 49'(bas[i]));
                    r_state <= S_LMUL;
                end
                S_LMUL: begin
                    for (int i = 0; i < 3; i++)
                        r_p2[i] <= (33'(r_v1[i]) - 33'(r_v0[i])) * $signed({1'b0, r_f});
                    r_state <= S_LADD;
                end
                S_LADD: begin
                    if (out_free) begin
                        o_x <= r_v0[0] + 32'(r_p2[0] >>> kvl_pkg::FRAC_BITS);
                        o_y <= r_v0[1] + 32'(r_p2[1] >>> kvl_pkg::FRAC_BITS);
                        o_z <= r_v0[2] + 32'(r_p2[2] >>> kvl_pkg::FRAC_BITS);
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/keyframe_vec3_lerp_sampler_core.sv
// top level of the keyframe vec3 lerp sampler
// depends on kvl_pkg, kvl_if, kvl_front, kvl_back
//
// usage:
//   i_req carries request transactions. req_type write stores one key
//   (time, x, y, z) at key_index and gives no result; req_type sample looks
//   up sample_time (fine units, key time times 1024) and gives one result
//   transaction on o_res with the interpolated x, y, z in Q16.16.
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (key count, then scale and base for x, y and z); write only when idle.
// flow:
//   a two-entry queue parts the front from the back, so requests are taken
//   while the back works. a key write is stored as it is popped. a sample
//   is popped, checked against the last key, then binary searched, each probe
//   a registered read on the one table read port; then the bracketing pair is
//   fetched, the fraction divider forms a 16-bit fraction, and the values are
//   dequantized and lerped. a last-key clamp or an exact hit skips the divider.
// reset: clears the queue, the sequencer and the result valid; the key table
//   holds nothing useful until written. registers return to their defaults.
// stall: a finished result waits in the output register; the back holds its
//   next result until the register frees, the queue takes requests until full.
module keyframe_vec3_lerp_sampler_core #(
    parameter int MAX_KEYS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    kvl_req_if.sink                            i_req,
    kvl_res_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [kvl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                        i_cfg_data
);
    kvl_pkg::t_cfg  r_cfg;
    logic           q_valid;
    kvl_pkg::t_item q_item;
    logic           q_pop;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_count <= 9'd1;
            r_cfg.x_scale   <= 32'sd65536;
            r_cfg.x_base    <= '0;
            r_cfg.y_scale   <= 32'sd65536;
            r_cfg.y_base    <= '0;
            r_cfg.z_scale   <= 32'sd65536;
            r_cfg.z_base    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kvl_pkg::CFG_KEY_COUNT: r_cfg.key_count <= i_cfg_data[8:0];
                kvl_pkg::CFG_X_SCALE:   r_cfg.x_scale   <= i_cfg_data;
                kvl_pkg::CFG_X_BASE:    r_cfg.x_base    <= i_cfg_data;
                kvl_pkg::CFG_Y_SCALE:   r_cfg.y_scale   <= i_cfg_data;
                kvl_pkg::CFG_Y_BASE:    r_cfg.y_base    <= i_cfg_data;
                kvl_pkg::CFG_Z_SCALE:   r_cfg.z_scale   <= i_cfg_data;
                kvl_pkg::CFG_Z_BASE:    r_cfg.z_base    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify transactions into the queue
    kvl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_req.valid),
        .o_ready       (i_req.ready),
        .i_req_type    (i_req.req_type),
        .i_key_index   (i_req.key_index),
        .i_key_time    (i_req.key_time),
        .i_key_x       (i_req.key_x),
        .i_key_y       (i_req.key_y),
        .i_key_z       (i_req.key_z),
        .i_sample_time (i_req.sample_time),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    // back: table, search, divide, interpolate, output register
    kvl_back #(.MAX_KEYS(MAX_KEYS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_x       (o_res.out_x),
        .o_y       (o_res.out_y),
        .o_z       (o_res.out_z)
    );
endmodule

FILE: hdl/kvl_checker.sv
// port-level checks for the sampler top level
// depends on keyframe_vec3_lerp_sampler_core; bound below
module kvl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [95:0] i_out_data
);
    // result register is cleared by reset
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // queue is empty after reset so requests are taken
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("request channel not ready after reset");

    // a stalled result holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");
endmodule

bind keyframe_vec3_lerp_sampler_core kvl_checker u_kvl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  ({o_res.out_x, o_res.out_y, o_res.out_z})
);

FILE: sim/tb_keyframe_vec3_lerp_sampler_core.sv
// testbench for keyframe_vec3_lerp_sampler_core: key table fills, samples and register sweeps
// predicts every sample result and checks o_res field by field
// depends on kvl_pkg, kvl_if and the rtl of the core
module tb_keyframe_vec3_lerp_sampler_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec_res;

    // scoreboard: shadow key table, shadow registers, queue of pending samples
    class track_scoreboard;
        kvl_pkg::t_key keys[TABLE_DEPTH];
        logic [8:0]    key_count;
        longint        scale[3];
        longint        offset[3];
        t_vec_res      pending[$];
        int            errors;
        int            samples_seen;
        int            writes_seen;

        function new();
            key_count = 9'd1;
            for (int c = 0; c < 3; c++) begin
                scale[c]  = 65536;
                offset[c] = 0;
            end
            errors = 0;
            samples_seen = 0;
            writes_seen = 0;
        endfunction

        function void set_reg(logic [kvl_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                kvl_pkg::CFG_KEY_COUNT: key_count = data[8:0];
                kvl_pkg::CFG_X_SCALE:   scale[0]  = longint'(signed'(data));
                kvl_pkg::CFG_X_BASE:    offset[0] = longint'(signed'(data));
                kvl_pkg::CFG_Y_SCALE:   scale[1]  = longint'(signed'(data));
                kvl_pkg::CFG_Y_BASE:    offset[1] = longint'(signed'(data));
                kvl_pkg::CFG_Z_SCALE:   scale[2]  = longint'(signed'(data));
                kvl_pkg::CFG_Z_BASE:    offset[2] = longint'(signed'(data));
                default: ;
            endcase
        endfunction

        function int active_keys();
            int n;
            n = key_count;
            if (n < 1) n = 1;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            return n;
        endfunction

        function longint fine_time(int k);
            return longint'(keys[k].time_c) << kvl_pkg::TIME_SHIFT;
        endfunction

        // q * scale + base, saturated to 32 bits
        function longint dequant(int c, int k);
            longint q;
            longint p;
            q = (c == 0) ? longint'(keys[k].x) : (c == 1) ? longint'(keys[k].y)
                                                          : longint'(keys[k].z);
            p = q * scale[c] + offset[c];
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            return p;
        endfunction

        function t_vec_res key_value(int k);
            t_vec_res r;
            r.x = 32'(dequant(0, k));
            r.y = 32'(dequant(1, k));
            r.z = 32'(dequant(2, k));
            return r;
        endfunction

        function longint blend(longint v0, longint v1, longint f);
            longint d;
            d = (v1 - v0) * f;
            return v0 + (d >>> 16);
        endfunction

        function t_vec_res sample_at(longint t);
            int       n;
            int       lo;
            int       hi;
            int       mid;
            int       i0;
            int       i1;
            longint   den;
            longint   num;
            longint   f;
            t_vec_res r;
            n = active_keys();
            lo = 0;
            hi = n - 1;
            if (t >= fine_time(hi)) return key_value(hi);
            while (lo <= hi) begin
                mid = (lo + hi) >> 1;
                if (t == fine_time(mid)) return key_value(mid);
                if (t > fine_time(mid)) lo = mid + 1;
                else hi = mid - 1;
            end
            if (hi < 0) return key_value(0);
            i0 = hi;
            i1 = (i0 + 1 > n - 1) ? n - 1 : i0 + 1;
            den = fine_time(i1) - fine_time(i0);
            if (den <= 0) return key_value(i0);
            num = t - fine_time(i0);
            if (num <= 0) f = 0;
            else if (num >= den) f = 65535;
            else f = (num * 65536) / den;
            r.x = 32'(blend(dequant(0, i0), dequant(0, i1), f));
            r.y = 32'(blend(dequant(1, i0), dequant(1, i1), f));
            r.z = 32'(blend(dequant(2, i0), dequant(2, i1), f));
            return r;
        endfunction

        function void note_request(kvl_pkg::t_item it);
            if (it.is_sample == kvl_pkg::REQ_SAMPLE) begin
                pending.push_back(sample_at(longint'(it.sample_time)));
                samples_seen++;
            end else begin
                keys[it.key_index] = '{time_c: it.key_time, x: it.key_x, y: it.key_y,
                                       z: it.key_z};
                writes_seen++;
            end
        endfunction

        function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z);
            t_vec_res e;
            if (pending.size() == 0) begin
                $error("result with no sample pending: x=%0d y=%0d z=%0d", x, y, z);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x) begin
                $error("out_x expected %0d actual %0d", e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $error("out_y expected %0d actual %0d", e.y, y);
                errors++;
            end
            if (z !== e.z) begin
                $error("out_z expected %0d actual %0d", e.z, z);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [kvl_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    kvl_req_if req_ch ();
    kvl_res_if res_ch ();

    keyframe_vec3_lerp_sampler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    track_scoreboard track = new();
    int send_idle_pct;
    int recv_idle_pct;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // all inputs known from time zero
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = kvl_pkg::REQ_WRITE;
        req_ch.key_index = '0;
        req_ch.key_time = '0;
        req_ch.key_x = '0;
        req_ch.key_y = '0;
        req_ch.key_z = '0;
        req_ch.sample_time = '0;
        res_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
    end

    // receiver stalls at the rate set for the current phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitors: sample pre-edge values, every tb drive is nonblocking
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            track.note_request('{is_sample: req_ch.req_type, key_index: req_ch.key_index,
                                 key_time: req_ch.key_time, key_x: req_ch.key_x,
                                 key_y: req_ch.key_y, key_z: req_ch.key_z,
                                 sample_time: req_ch.sample_time});
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            track.check_result(res_ch.out_x, res_ch.out_y, res_ch.out_z);
        end
    end

    // one request transaction, held until the handshake
    task automatic send_item(logic kind, logic [7:0] idx, logic [15:0] kt,
                             logic [15:0] kx, logic [15:0] ky, logic [15:0] kz,
                             logic [31:0] st);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.key_index <= idx;
        req_ch.key_time <= kt;
        req_ch.key_x <= kx;
        req_ch.key_y <= ky;
        req_ch.key_z <= kz;
        req_ch.sample_time <= st;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic send_key(int idx, int kt, logic [15:0] kx, logic [15:0] ky,
                            logic [15:0] kz);
        send_item(kvl_pkg::REQ_WRITE, idx[7:0], kt[15:0], kx, ky, kz, $urandom());
    endtask

    task automatic send_sample(longint t);
        send_item(kvl_pkg::REQ_SAMPLE, 8'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), t[31:0]);
    endtask

    // no transaction in flight before touching registers; writes give no result,
    // so the back gets time to finish them
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (track.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [8:0] count, logic [31:0] sc[3], logic [31:0] bs[3]);
        logic [kvl_pkg::CFG_IDX_W-1:0] idx_list[7];
        logic [31:0]                   val_list[7];
        idx_list = '{kvl_pkg::CFG_KEY_COUNT, kvl_pkg::CFG_X_SCALE, kvl_pkg::CFG_X_BASE,
                     kvl_pkg::CFG_Y_SCALE, kvl_pkg::CFG_Y_BASE, kvl_pkg::CFG_Z_SCALE,
                     kvl_pkg::CFG_Z_BASE};
        val_list = '{{23'd0, count}, sc[0], bs[0], sc[1], bs[1], sc[2], bs[2]};
        for (int i = 0; i < 7; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx_list[i];
            i_cfg_data <= val_list[i];
            @(posedge i_clk);
            track.set_reg(idx_list[i], val_list[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // sorted key times with random steps, zero steps give duplicate times
    task automatic fill_keys(int cnt, int step_max);
        int t;
        t = 0;
        for (int i = 0; i < cnt; i++) begin
            t += $urandom_range(0, step_max);
            if (t > 65535 || i == TABLE_DEPTH - 1) t = 65535;
            if (i == 0) send_key(i, t, 16'h8000, 16'h7fff, 16'h8000);
            else if (i == 1) send_key(i, t, 16'h7fff, 16'h8000, 16'h7fff);
            else send_key(i, t, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        end
    endtask

    function automatic longint pick_time();
        int     r;
        int     j;
        longint t;
        r = $urandom_range(0, 99);
        j = $urandom_range(0, track.active_keys() - 1);
        t = track.fine_time(j);
        if (r < 10) return longint'(signed'($urandom()));
        if (r < 35) return t;
        return t + $urandom_range(0, 60000) - 4096;
    endfunction

    // mostly in-order key rewrites so the search still sees a sorted track
    task automatic random_key_write();
        int j;
        int lo;
        int hi;
        if ($urandom_range(0, 9) == 0) begin
            send_key($urandom_range(0, 255), $urandom_range(0, 65535), 16'($urandom()),
                     16'($urandom()), 16'($urandom()));
        end else begin
            j = $urandom_range(0, track.active_keys() - 1);
            lo = (j > 0) ? track.keys[j-1].time_c : 0;
            hi = (j < TABLE_DEPTH - 1) ? track.keys[j+1].time_c : 65535;
            if (lo > hi) hi = lo;
            send_key(j, $urandom_range(lo, hi), 16'($urandom()), 16'($urandom()),
                     16'($urandom()));
        end
    endtask

    initial begin
        logic [31:0] sc[3];
        logic [31:0] bs[3];
        logic [8:0]  count;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every slot once so no sample ever reads an unwritten key
        send_idle_pct = 37;
        recv_idle_pct = 81;
        fill_keys(TABLE_DEPTH, 256);
        wait_idle();
        sc = '{32'd65536, 32'd65536, 32'd65536};
        bs = '{32'd0, 32'd0, 32'd0};
        write_regs(9'd256, sc, bs);

        // directed: clamps both ends, exact hits, midpoints, full-range times
        send_sample(longint'(-64'sd2147483648));
        send_sample(64'sd2147483647);
        send_sample(track.fine_time(0) - 1);
        send_sample(track.fine_time(0));
        send_sample(track.fine_time(255));
        send_sample(track.fine_time(255) - 1);
        send_sample(track.fine_time(128));
        send_sample(track.fine_time(100) + 512);
        send_sample((track.fine_time(7) + track.fine_time(8)) / 2);
        // key out of order: search falls on a negative interval
        send_key(50, 0, 16'h1234, 16'hedcb, 16'h0001);
        send_sample(track.fine_time(49) + 100);
        send_sample(track.fine_time(51) - 1);
        send_key(50, 65535, 16'h7fff, 16'h8000, 16'h0000);
        send_sample(track.fine_time(49) + 3);
        send_sample(track.fine_time(50) - 1);

        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 37 : (phase < 4) ? 81 : 0;
            recv_idle_pct = (phase < 2) ? 81 : (phase < 4) ? 37 : 0;
            wait_idle();
            for (int c = 0; c < 3; c++) begin
                sc[c] = $urandom_range(0, 1) ? $urandom_range(0, 1 << 21) - (1 << 20)
                                              : $urandom();
                bs[c] = $urandom();
            end
            case (phase)
                0: count = 9'd256;
                1: begin
                    count = 9'd2;
                    sc = '{32'h80000000, 32'h80000000, 32'h7fffffff};
                    bs = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
                end
                2: begin
                    count = 9'd511;
                    sc = '{32'h7fffffff, 32'd0, 32'h80000000};
                    bs = '{32'h80000000, 32'h7fffffff, 32'd0};
                end
                3: count = 9'($urandom_range(1, 256));
                4: count = 9'd0;
                default: count = 9'($urandom_range(3, 40));
            endcase
            write_regs(count, sc, bs);
            if (phase == 3) fill_keys(track.active_keys(), 2000);
            else if (phase == 5) fill_keys(track.active_keys(), 40);
            for (int i = 0; i < 240; i++) begin
                if ($urandom_range(0, 99) < 20) random_key_write();
                else send_sample(pick_time());
            end
        end

        wait_idle();
        $display("ran %0d key writes and %0d samples over six register settings",
                 track.writes_seen, track.samples_seen);
        $display("idle mixes: sender-heavy, receiver-heavy and back-to-back");
        if (track.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
